FILE: sv/rgtd_pkg.sv
// Shared types and constants for the RDS group text decoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rgtd_pkg;

   localparam int STORE_CHARS_DEFAULT = 64;

   // Character positions within one store row (four bytes per row)
   localparam int LANES = 4;

   typedef enum logic [1:0] {
      MODE_POLL       = 2'd0,
      MODE_GROUP      = 2'd1,
      MODE_INVALIDATE = 2'd2,
      MODE_READ       = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CSR_ENABLE  = 2'd0,
      CSR_STARTUP = 2'd1,
      CSR_TIMEOUT = 2'd2
   } csr_index_type;

   localparam logic [3:0] GTYPE_SERVICE = 4'd0;
   localparam logic [3:0] GTYPE_TEXT    = 4'd2;

   localparam logic       ENABLE_RESET  = 1'b1;
   localparam logic [7:0] STARTUP_RESET = 8'd50;
   localparam logic [7:0] TIMEOUT_RESET = 8'd15;

   // Byte-enable write into a four-character row
   typedef struct packed {
      logic [LANES-1:0]      lane_en;
      logic [3:0]            row;
      logic [LANES-1:0][7:0] data;
   } wr_req_type;

   // Decoder state after an item has been applied
   typedef struct packed {
      logic        avail;
      logic [15:0] block2;
      logic [4:0]  text;
   } status_type;

endpackage

`default_nettype wire

FILE: sv/rgtd_char_store.sv
// One 64-character store, kept as rows of four bytes with byte-enable writes.
// Per-character valid bits give the all-zero reset and clear. Uses rgtd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgtd_char_store
   import rgtd_pkg::*;
#(
   parameter int STORE_CHARS = STORE_CHARS_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       clear,
   input  wire wr_req_type wr,
   input  wire logic       rd_en,
   input  wire logic [5:0] rd_index,
   output logic [7:0]      rd_char
);

   localparam int ROWS   = (STORE_CHARS + LANES - 1) / LANES;
   localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic [LANES-1:0][7:0] mem_ff [ROWS];
   logic [LANES-1:0]      valid_ff [ROWS];
   logic [LANES-1:0]      valid_in [ROWS];

   logic [LANES-1:0]      lane_ok;
   logic [ROW_AW-1:0]     wr_row;
   logic [ROW_AW-1:0]     rd_row;
   logic [5:0]            pos;

   logic [LANES-1:0][7:0] rd_data_ff;
   logic [LANES-1:0]      rd_valid_ff;
   logic [1:0]            rd_lane_ff;
   logic                  rd_range_ff;

   assign wr_row = ROW_AW'(wr.row);
   assign rd_row = ROW_AW'(rd_index[5:2]);

   // characters past the end of the store are dropped lane by lane
   always_comb begin
      pos = '0;
      for (int l = 0; l < LANES; l++) begin
         pos        = {wr.row, 2'(l)};
         lane_ok[l] = wr.lane_en[l] && (int'(pos) < STORE_CHARS);
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < LANES; l++) begin
         if (lane_ok[l]) begin
            mem_ff[wr_row][l] <= wr.data[l];
         end
      end
   end

   always_comb begin
      for (int r = 0; r < ROWS; r++) begin
         valid_in[r] = valid_ff[r];
         if (clear) begin
            valid_in[r] = '0;
         end else if (wr_row == ROW_AW'(r)) begin
            valid_in[r] = valid_ff[r] | lane_ok;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < ROWS; r++) begin
         if (reset) begin
            valid_ff[r] <= '0;
         end else begin
            valid_ff[r] <= valid_in[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem_ff[rd_row];
         rd_valid_ff <= valid_ff[rd_row];
         rd_lane_ff  <= rd_index[1:0];
         rd_range_ff <= int'(rd_index) < STORE_CHARS;
      end
   end

   assign rd_char = (rd_range_ff && rd_valid_ff[rd_lane_ff]) ? rd_data_ff[rd_lane_ff] : 8'd0;

endmodule

`default_nettype wire

FILE: sv/rgtd_ctrl.sv
// Decoder control: configuration registers, startup and loss counters,
// latched block 2 and radio text fields, store write requests. Uses rgtd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgtd_ctrl
   import rgtd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_data,
   input  wire logic        item_valid,
   input  wire mode_type    mode,
   input  wire logic [15:0] block2,
   input  wire logic [15:0] block3,
   input  wire logic [15:0] block4,
   output wr_req_type       svc_wr,
   output wr_req_type       txt_wr,
   output logic             clear_stores,
   output status_type       status
);

   logic       enable_ff, enable_in;
   logic [7:0] startup_ff, startup_in;
   logic [7:0] timeout_ff, timeout_in;
   logic       csr_clear;

   logic [7:0]  delay_ff, delay_in;
   logic [7:0]  loss_ff, loss_in;
   logic        avail_ff, avail_in;
   logic [15:0] block2_ff, block2_in;
   logic [4:0]  text_ff, text_in;
   logic        item_clear;

   always_comb begin
      enable_in  = enable_ff;
      startup_in = startup_ff;
      timeout_in = timeout_ff;
      csr_clear  = 1'b0;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_ENABLE: begin
               enable_in = csr_data[0];
               csr_clear = !csr_data[0];
            end
            CSR_STARTUP: startup_in = csr_data;
            CSR_TIMEOUT: timeout_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      delay_in   = delay_ff;
      loss_in    = loss_ff;
      avail_in   = avail_ff;
      block2_in  = block2_ff;
      text_in    = text_ff;
      item_clear = 1'b0;
      svc_wr     = '0;
      txt_wr     = '0;
      if (item_valid) begin
         case (mode)
            MODE_INVALIDATE: begin
               avail_in   = 1'b0;
               delay_in   = '0;
               item_clear = 1'b1;
            end
            MODE_READ: ;
            default: begin
               if (enable_ff) begin
                  if (delay_ff < startup_ff) begin
                     delay_in = delay_ff + 8'd1;
                  end else if (mode == MODE_POLL) begin
                     if (loss_ff >= timeout_ff) begin
                        loss_in  = '0;
                        avail_in = 1'b0;
                     end else begin
                        loss_in = loss_ff + 8'd1;
                     end
                  end else begin
                     loss_in   = '0;
                     avail_in  = 1'b1;
                     block2_in = block2;
                     case (block2[15:12])
                        GTYPE_SERVICE: begin
                           // segment*2 lands in row segment/2, low or high half
                           svc_wr.lane_en = block2[0] ? 4'b1100 : 4'b0011;
                           svc_wr.row     = {3'b000, block2[1]};
                           svc_wr.data    = {block4[7:0], block4[15:8],
                                             block4[7:0], block4[15:8]};
                        end
                        GTYPE_TEXT: begin
                           text_in = block2[4:0];
                           if (!block2[11]) begin
                              txt_wr.lane_en = 4'b1111;
                              txt_wr.row     = block2[3:0];
                              txt_wr.data    = {block4[7:0], block4[15:8],
                                                block3[7:0], block3[15:8]};
                           end else begin
                              txt_wr.lane_en = block2[0] ? 4'b1100 : 4'b0011;
                              txt_wr.row     = {1'b0, block2[3:1]};
                              txt_wr.data    = {block4[7:0], block4[15:8],
                                                block4[7:0], block4[15:8]};
                           end
                        end
                        default: ;
                     endcase
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= ENABLE_RESET;
         startup_ff <= STARTUP_RESET;
         timeout_ff <= TIMEOUT_RESET;
         delay_ff   <= '0;
         loss_ff    <= '0;
         avail_ff   <= 1'b0;
         block2_ff  <= '0;
         text_ff    <= '0;
      end else begin
         enable_ff  <= enable_in;
         startup_ff <= startup_in;
         timeout_ff <= timeout_in;
         delay_ff   <= delay_in;
         loss_ff    <= loss_in;
         avail_ff   <= avail_in;
         block2_ff  <= block2_in;
         text_ff    <= text_in;
      end
   end

   assign clear_stores  = csr_clear || item_clear;
   assign status.avail  = avail_in;
   assign status.block2 = block2_in;
   assign status.text   = text_in;

endmodule

`default_nettype wire

FILE: sv/rds_group_text_decoder.sv
// RDS group text decoder: input register, control, two character stores and
// result register. Depends on rgtd_pkg, rgtd_ctrl and rgtd_char_store.
//
// Usage:
//   req_* carries one item per transfer: tuser is the mode (empty poll, group,
//   invalidate, read), tdata the block 2..4 words and the read address.
//   rsp_* returns exactly one result per item, in order: the latched block 2
//   fields, radio text A/B flag and segment, data-available flag, and the
//   character read (zero for items that are not reads).
//   csr_* writes decoder_enable (0), startup_delay (1) and loss_timeout (2);
//   other indexes are ignored. Write only while no item is in flight.
// Path: the item is registered in the input register, and its result is
// registered in the result register once that register can take it.
// Throughput: one item per cycle unless the result stalls; items pass one input
// register, the control logic and the store read port, then the result register.
// Reset: configuration returns to 1 / 50 / 15, the counters, flags and
// latched fields clear, and both stores read as zero at once (per-character
// valid bits, no clearing pass).
// Stall: while rsp_tready is low the result holds, one more item is taken
// into the input register, then req_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module rds_group_text_decoder
   import rgtd_pkg::*;
#(
   parameter int STORE_CHARS = STORE_CHARS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [15:0] block2_word, [31:16] block3_word, [47:32] block4_word,
   // [48] store_select, [54:49] read_index, [55] zero
   input  wire logic [55:0] req_tdata,
   // [1:0] mode
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] data_available, [4:1] group_type, [5] group_version,
   // [6] traffic_program, [11:7] program_type, [12] traffic_announce,
   // [13] music_speech, [14] decoder_info, [16:15] ps_segment,
   // [17] text_ab_flag, [21:18] text_segment, [29:22] read_char, [31:30] zero
   output logic [31:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_data
);

   logic        a_valid_ff, a_valid_in;
   mode_type    a_mode_ff;
   logic [15:0] a_b2_ff, a_b3_ff, a_b4_ff;
   logic        a_sel_ff;
   logic [5:0]  a_idx_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   status_type  b_status_ff;
   logic        b_read_ff;
   logic        b_sel_ff;

   logic        req_xfer;
   logic        advance;
   logic        rd_en;
   wr_req_type  svc_wr, txt_wr;
   logic        clear_stores;
   status_type  status;
   logic [7:0]  svc_char, txt_char;
   logic [7:0]  read_char;

   assign csr_ready  = 1'b1;
   assign advance    = a_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !a_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;
   assign rd_en      = advance && (a_mode_ff == MODE_READ);

   assign a_valid_in   = req_xfer || (a_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         a_mode_ff <= mode_type'(req_tuser);
         a_b2_ff   <= req_tdata[15:0];
         a_b3_ff   <= req_tdata[31:16];
         a_b4_ff   <= req_tdata[47:32];
         a_sel_ff  <= req_tdata[48];
         a_idx_ff  <= req_tdata[54:49];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_status_ff <= status;
         b_read_ff   <= a_mode_ff == MODE_READ;
         b_sel_ff    <= a_sel_ff;
      end
   end

   rgtd_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_valid && csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .item_valid   (advance),
      .mode         (a_mode_ff),
      .block2       (a_b2_ff),
      .block3       (a_b3_ff),
      .block4       (a_b4_ff),
      .svc_wr       (svc_wr),
      .txt_wr       (txt_wr),
      .clear_stores (clear_stores),
      .status       (status)
   );

   rgtd_char_store #(.STORE_CHARS(STORE_CHARS)) u_svc_store (
      .clock    (clock),
      .reset    (reset),
      .clear    (clear_stores),
      .wr       (svc_wr),
      .rd_en    (rd_en),
      .rd_index (a_idx_ff),
      .rd_char  (svc_char)
   );

   rgtd_char_store #(.STORE_CHARS(STORE_CHARS)) u_txt_store (
      .clock    (clock),
      .reset    (reset),
      .clear    (clear_stores),
      .wr       (txt_wr),
      .rd_en    (rd_en),
      .rd_index (a_idx_ff),
      .rd_char  (txt_char)
   );

   assign read_char = b_read_ff ? (b_sel_ff ? txt_char : svc_char) : 8'd0;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00,
                        read_char,
                        b_status_ff.text[3:0],
                        b_status_ff.text[4],
                        b_status_ff.block2[1:0],
                        b_status_ff.block2[2],
                        b_status_ff.block2[3],
                        b_status_ff.block2[4],
                        b_status_ff.block2[9:5],
                        b_status_ff.block2[10],
                        b_status_ff.block2[11],
                        b_status_ff.block2[15:12],
                        b_status_ff.avail};

   // input side only backs up when the result register is full and stalled
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (a_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("input stalled without a stalled result");

   // an invalidate always reports the flag cleared
   assert property (@(posedge clock) disable iff (reset)
      (advance && a_mode_ff == MODE_INVALIDATE) |=> (rsp_tvalid && !rsp_tdata[0]))
      else $error("invalidate left data_available set");

   // a new result only appears when an item left the input register
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(advance))
      else $error("result appeared without an item");

endmodule

`default_nettype wire

FILE: tb/sv/rgtd_checker.sv
// Checker for the RDS group text decoder: watches the request, result and CSR
// channels, predicts every result and compares it field by field.
// Depends on rgtd_pkg.
`timescale 1ns / 1ps

module rgtd_checker
   import rgtd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [55:0] req_tdata,
   input  wire logic [1:0]  req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_data,
   output int               mismatches,
   output int               pending,
   output int               checked
);

   localparam int STORE_CHARS = STORE_CHARS_DEFAULT;

   // Same layout as rsp_tdata, lowest field declared last
   typedef struct packed {
      logic [1:0] pad;
      logic [7:0] read_char;
      logic [3:0] text_segment;
      logic       text_ab_flag;
      logic [1:0] ps_segment;
      logic       decoder_info;
      logic       music_speech;
      logic       traffic_announce;
      logic [4:0] program_type;
      logic       traffic_program;
      logic       group_version;
      logic [3:0] group_type;
      logic       data_available;
   } status_word_type;

   logic        cfg_enable;
   logic [7:0]  cfg_startup;
   logic [7:0]  cfg_timeout;
   logic [7:0]  delay_count;
   logic [7:0]  loss_count;
   logic        avail;
   logic [7:0]  ps_chars [STORE_CHARS];
   logic [7:0]  rt_chars [STORE_CHARS];
   logic [15:0] block2;
   logic [4:0]  text_bits;

   status_word_type status_q [$];
   int err_count = 0;
   int got_count = 0;

   function automatic void clear_chars();
      foreach (ps_chars[i]) begin
         ps_chars[i] = '0;
         rt_chars[i] = '0;
      end
   endfunction

   function automatic void reset_model();
      cfg_enable  = ENABLE_RESET;
      cfg_startup = STARTUP_RESET;
      cfg_timeout = TIMEOUT_RESET;
      delay_count = '0;
      loss_count  = '0;
      avail       = 1'b0;
      block2      = '0;
      text_bits   = '0;
      clear_chars();
   endfunction

   function automatic void write_cfg(logic [1:0] idx, logic [7:0] val);
      case (idx)
         CSR_ENABLE: begin
            cfg_enable = val[0];
            if (!cfg_enable) clear_chars();
         end
         CSR_STARTUP: cfg_startup = val;
         CSR_TIMEOUT: cfg_timeout = val;
         default: ;
      endcase
   endfunction

   // Characters past the end of a store are dropped
   function automatic void put_char(logic to_text, int pos, logic [7:0] ch);
      if (pos < STORE_CHARS) begin
         if (to_text) rt_chars[pos] = ch;
         else ps_chars[pos] = ch;
      end
   endfunction

   function automatic void take_group(logic [15:0] b2, logic [15:0] b3, logic [15:0] b4);
      int seg;
      loss_count = '0;
      avail      = 1'b1;
      block2     = b2;
      if (b2[15:12] == GTYPE_SERVICE) begin
         seg = int'(b2[1:0]);
         put_char(1'b0, seg * 2, b4[15:8]);
         put_char(1'b0, seg * 2 + 1, b4[7:0]);
      end else if (b2[15:12] == GTYPE_TEXT) begin
         text_bits = b2[4:0];
         seg = int'(b2[3:0]);
         if (!b2[11]) begin
            put_char(1'b1, seg * 4, b3[15:8]);
            put_char(1'b1, seg * 4 + 1, b3[7:0]);
            put_char(1'b1, seg * 4 + 2, b4[15:8]);
            put_char(1'b1, seg * 4 + 3, b4[7:0]);
         end else begin
            put_char(1'b1, seg * 2, b4[15:8]);
            put_char(1'b1, seg * 2 + 1, b4[7:0]);
         end
      end
   endfunction

   function automatic status_word_type decode_item(mode_type m, logic [55:0] d);
      logic [7:0]      rd;
      int              idx;
      status_word_type s;
      rd  = '0;
      idx = int'(d[54:49]);
      case (m)
         MODE_INVALIDATE: begin
            avail       = 1'b0;
            delay_count = '0;
            clear_chars();
         end
         MODE_READ: begin
            if (idx < STORE_CHARS) rd = d[48] ? rt_chars[idx] : ps_chars[idx];
         end
         default: begin
            if (!cfg_enable) begin
               // disabled: polls and groups are dropped
            end else if (delay_count < cfg_startup) begin
               delay_count++;
            end else if (m == MODE_POLL) begin
               if (loss_count >= cfg_timeout) begin
                  loss_count = '0;
                  avail      = 1'b0;
               end else begin
                  loss_count++;
               end
            end else begin
               take_group(d[15:0], d[31:16], d[47:32]);
            end
         end
      endcase
      s.pad              = '0;
      s.read_char        = rd;
      s.text_segment     = text_bits[3:0];
      s.text_ab_flag     = text_bits[4];
      s.ps_segment       = block2[1:0];
      s.decoder_info     = block2[2];
      s.music_speech     = block2[3];
      s.traffic_announce = block2[4];
      s.program_type     = block2[9:5];
      s.traffic_program  = block2[10];
      s.group_version    = block2[11];
      s.group_type       = block2[15:12];
      s.data_available   = avail;
      return s;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         err_count++;
      end
   endfunction

   function automatic void compare_status(status_word_type want, status_word_type got);
      check_field("data_available", want.data_available, got.data_available);
      check_field("group_type", want.group_type, got.group_type);
      check_field("group_version", want.group_version, got.group_version);
      check_field("traffic_program", want.traffic_program, got.traffic_program);
      check_field("program_type", want.program_type, got.program_type);
      check_field("traffic_announce", want.traffic_announce, got.traffic_announce);
      check_field("music_speech", want.music_speech, got.music_speech);
      check_field("decoder_info", want.decoder_info, got.decoder_info);
      check_field("ps_segment", want.ps_segment, got.ps_segment);
      check_field("text_ab_flag", want.text_ab_flag, got.text_ab_flag);
      check_field("text_segment", want.text_segment, got.text_segment);
      check_field("read_char", want.read_char, got.read_char);
      check_field("pad", want.pad, got.pad);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         reset_model();
         status_q.delete();
      end else begin
         if (csr_valid && csr_ready) write_cfg(csr_index, csr_data);
         // pop before push: a result never belongs to an item of the same edge
         if (rsp_tvalid && rsp_tready) begin
            if (status_q.size() == 0) begin
               $error("result transfer with nothing expected: %h", rsp_tdata);
               err_count++;
            end else begin
               compare_status(status_q.pop_front(), status_word_type'(rsp_tdata));
               got_count++;
            end
         end
         if (req_tvalid && req_tready)
            status_q.push_back(decode_item(mode_type'(req_tuser), req_tdata));
      end
      mismatches <= err_count;
      pending    <= status_q.size();
      checked    <= got_count;
   end

endmodule

FILE: tb/sv/tb_rds_group_text_decoder.sv
// Top of the RDS group text decoder testbench: clock, reset, stimulus and
// verdict. Depends on rgtd_pkg, rgtd_checker and rds_group_text_decoder.
`timescale 1ns / 1ps

module tb_rds_group_text_decoder;
   import rgtd_pkg::*;

   localparam logic [1:0] CSR_UNUSED  = 2'd3;
   localparam int         PHASE_ITEMS = 342;
   localparam int         DRAIN_LIMIT = 20000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = MODE_POLL;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = CSR_ENABLE;
   logic [7:0]  csr_data   = '0;

   int mismatches;
   int pending;
   int checked;

   int send_gap_pct  = 7;
   int rsp_stall_pct = 50;
   int inval_pct     = 2;
   int items_sent    = 0;
   int target;

   rds_group_text_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   rgtd_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .mismatches (mismatches),
      .pending    (pending),
      .checked    (checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);

   initial begin
      #3_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic send_item(input mode_type m, input logic [15:0] b2, input logic [15:0] b3,
                            input logic [15:0] b4, input logic sel, input logic [5:0] idx);
      // each cycle the sender idles with probability send_gap_pct
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= m;
      req_tdata  <= {1'b0, idx, sel, b4, b3, b2};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // leaves csr_valid high; the caller lowers it after the last write
   task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic drain();
      int n;
      n = 0;
      req_tvalid <= 1'b0;
      do begin
         @(posedge clock);
         n++;
      end while (pending != 0 && n < DRAIN_LIMIT);
   endtask

   task automatic send_random_item();
      int          pick;
      logic [15:0] b2;
      logic        sel;
      pick = $urandom_range(99);
      b2   = 16'($urandom);
      sel  = 1'($urandom);
      if (pick < 45) begin
         case ($urandom_range(4))
            0, 1: b2[15:12] = GTYPE_SERVICE;
            2, 3: b2[15:12] = GTYPE_TEXT;
            default: ;
         endcase
         send_item(MODE_GROUP, b2, 16'($urandom), 16'($urandom), 1'($urandom),
                   6'($urandom));
      end else if (pick < 75) begin
         // service reads mostly land on the eight positions that groups write
         send_item(MODE_READ, 16'($urandom), 16'($urandom), 16'($urandom), sel,
                   (sel || pick > 70) ? 6'($urandom) : 6'($urandom_range(7)));
      end else if (pick < 100 - inval_pct) begin
         // occasional poll bursts run past the loss timeout
         repeat (($urandom_range(9) == 0) ? $urandom_range(20, 2) : 1)
            send_item(MODE_POLL, 16'($urandom), 16'($urandom), 16'($urandom),
                      1'($urandom), 6'($urandom));
      end else begin
         send_item(MODE_INVALIDATE, 16'($urandom), 16'($urandom), 16'($urandom),
                   1'($urandom), 6'($urandom));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_reg(CSR_STARTUP, 8'd3);
      write_reg(CSR_TIMEOUT, 8'd0);
      write_reg(CSR_UNUSED, 8'hFF);
      csr_valid <= 1'b0;

      // directed: startup hold-off, every group kind at its extreme segment,
      // loss with zero timeout, read-back, invalidate, disabled decoder
      send_item(MODE_READ, 16'h0, 16'h0, 16'h0, 1'b0, 6'd0);
      send_item(MODE_POLL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 6'd63);
      send_item(MODE_GROUP, {GTYPE_SERVICE, 12'h003}, 16'h0, 16'h5A5A, 1'b0, 6'd0);
      send_item(MODE_POLL, 16'h0, 16'h0, 16'h0, 1'b0, 6'd0);
      send_item(MODE_GROUP, {GTYPE_SERVICE, 12'h003}, 16'h1111, 16'h5241, 1'b0, 6'd0);
      send_item(MODE_GROUP, {GTYPE_TEXT, 12'h01F}, 16'hFFFF, 16'h8001, 1'b1, 6'd63);
      send_item(MODE_GROUP, {GTYPE_TEXT, 12'h81F}, 16'h7777, 16'h4142, 1'b0, 6'd0);
      send_item(MODE_GROUP, {GTYPE_TEXT, 12'h000}, 16'h0000, 16'h00FF, 1'b0, 6'd0);
      send_item(MODE_GROUP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 6'd63);
      send_item(MODE_POLL, 16'h0, 16'h0, 16'h0, 1'b0, 6'd0);
      send_item(MODE_POLL, 16'h0, 16'h0, 16'h0, 1'b0, 6'd0);
      send_item(MODE_READ, 16'h0, 16'h0, 16'h0, 1'b1, 6'd63);
      send_item(MODE_READ, 16'h0, 16'h0, 16'h0, 1'b1, 6'd30);
      send_item(MODE_READ, 16'h0, 16'h0, 16'h0, 1'b0, 6'd7);
      send_item(MODE_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 6'd63);
      send_item(MODE_GROUP, {GTYPE_SERVICE, 12'h000}, 16'h0, 16'h0, 1'b0, 6'd0);
      send_item(MODE_INVALIDATE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 6'd63);
      send_item(MODE_READ, 16'h0, 16'h0, 16'h0, 1'b1, 6'd60);
      send_item(MODE_GROUP, {GTYPE_TEXT, 12'h005}, 16'hABCD, 16'hEF01, 1'b0, 6'd0);
      drain();

      write_reg(CSR_ENABLE, 8'd0);
      write_reg(CSR_STARTUP, 8'd0);
      csr_valid <= 1'b0;
      send_item(MODE_GROUP, {GTYPE_SERVICE, 12'h002}, 16'h1234, 16'h4344, 1'b0, 6'd0);
      send_item(MODE_POLL, 16'h0, 16'h0, 16'h0, 1'b0, 6'd0);
      send_item(MODE_READ, 16'h0, 16'h0, 16'h0, 1'b0, 6'd6);
      send_item(MODE_INVALIDATE, 16'h0, 16'h0, 16'h0, 1'b0, 6'd0);
      drain();

      write_reg(CSR_ENABLE, 8'd1);
      write_reg(CSR_TIMEOUT, 8'd255);
      csr_valid <= 1'b0;
      send_item(MODE_GROUP, {GTYPE_TEXT, 12'h013}, 16'h5253, 16'h5455, 1'b0, 6'd0);
      send_item(MODE_READ, 16'h0, 16'h0, 16'h0, 1'b1, 6'd12);
      drain();

      // random, sender idles rarely, receiver often
      write_reg(CSR_STARTUP, 8'd0);
      write_reg(CSR_TIMEOUT, 8'd3);
      csr_valid <= 1'b0;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) send_random_item();
      drain();

      // random, pacing swapped; longest hold-off and timeout, no invalidates
      send_gap_pct  = 50;
      rsp_stall_pct = 7;
      inval_pct     = 0;
      write_reg(CSR_STARTUP, 8'd255);
      write_reg(CSR_TIMEOUT, 8'd255);
      csr_valid <= 1'b0;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) send_random_item();
      drain();

      // random, back to back at full rate
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      inval_pct     = 2;
      write_reg(CSR_ENABLE, 8'd0);
      write_reg(CSR_ENABLE, 8'd1);
      write_reg(CSR_STARTUP, 8'($urandom_range(8)));
      write_reg(CSR_TIMEOUT, 8'($urandom_range(6)));
      csr_valid <= 1'b0;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) send_random_item();
      drain();
      repeat (5) @(posedge clock);

      $display("Sent %0d items and checked %0d results over three pacing phases,",
               items_sent, checked);
      $display("with the decoder on and off, hold-off 0..255 and loss timeout 0..255.");
      if (mismatches == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
